FILE: design/fgf_pkg.sv
// Shared constants, controller states and command/status types of the gap finder.
package fgf_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MIN_GAP_W      = 16;
    localparam int MIN_GAP_SQ_W   = 2 * MIN_GAP_W;
    localparam int MIN_GAP_RESET  = 1000;
    localparam logic [MIN_GAP_SQ_W-1:0] MIN_GAP_SQ_RESET =
        MIN_GAP_SQ_W'(MIN_GAP_RESET * MIN_GAP_RESET);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_GAP,
        ST_CROSS,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    // Operand pair for the shared multiplier
    typedef enum logic [1:0] {
        MUL_DX,
        MUL_DY,
        MUL_AB,
        MUL_BA
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     load_d2;
        logic     load_cross;
        logic     decide;
        logic     update_prev;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic gap_ok;
        logic last;
        logic out_busy;
    } status_t;

endpackage

FILE: design/fgf_ctrl.sv
// Controller state machine: sequences one segment through the shared multiplier.
module fgf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  fgf_pkg::status_t status,
    output fgf_pkg::cmd_t    cmd
);
    import fgf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.have_prev ? ST_SQ_DX : ST_FINISH;
                end
            end
            ST_SQ_DX:
            begin
                state_next = ST_SQ_DY;
            end
            ST_SQ_DY:
            begin
                state_next = ST_GAP;
            end
            ST_GAP:
            begin
                state_next = status.gap_ok ? ST_CROSS : ST_FINISH;
            end
            ST_CROSS:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.last || !status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd      = '0;
        cmd.mul_sel = MUL_DX;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_SQ_DX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
            end
            ST_SQ_DY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DY;
                cmd.load_d2 = 1'b1;
            end
            ST_GAP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AB;
            end
            ST_CROSS:
            begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_BA;
                cmd.load_cross = 1'b1;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.update_prev = !status.last;
                cmd.emit        = status.last && !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: design/fgf_datapath.sv
// Datapath: segment capture, shared multiplier, gap test, cosine compare, result register.
module fgf_datapath #(
    parameter int COORD_BITS = fgf_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [fgf_pkg::MIN_GAP_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]         in_data,
    input  logic                         in_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [OUT_DATA_W-1:0]        out_data,
    output logic                         out_user,
    input  fgf_pkg::cmd_t                cmd,
    output fgf_pkg::status_t             status
);
    import fgf_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int O     = COORD_BITS + 1;
    localparam int MUL_W = (O > MIN_GAP_W) ? O : MIN_GAP_W;
    localparam int P_W   = 2 * MUL_W;

    // Scan state
    logic [C-1:0] prev_x_reg, prev_y_reg;
    logic         have_prev_reg;
    logic         have_best_reg;
    logic [O-1:0] best_x_reg, best_y_reg;
    logic [MIN_GAP_SQ_W-1:0] min_gap_sq_reg;

    // Per-segment working registers
    logic [C-1:0] end_x_reg, end_y_reg;
    logic         last_reg;
    logic [C-1:0] dxm_reg, dym_reg;
    logic [O-1:0] mx_reg, my_reg;
    logic [P_W-1:0] p_reg, d2_reg, cross_reg;

    // Result register
    logic           out_valid_reg;
    logic           found_reg;
    logic [O-1:0]   ox_reg, oy_reg;

    // Unpack the input transaction
    logic [C-1:0] sx, sy, ex, ey;
    assign sx = in_data[C-1:0];
    assign sy = in_data[2*C-1:C];
    assign ex = in_data[3*C-1:2*C];
    assign ey = in_data[4*C-1:3*C];

    // Gap vector and doubled midpoint against the previous end point
    logic [O-1:0] dx_full, dy_full, dx_abs, dy_abs, mx_next, my_next;
    assign dx_full = {sx[C-1], sx} - {prev_x_reg[C-1], prev_x_reg};
    assign dy_full = {sy[C-1], sy} - {prev_y_reg[C-1], prev_y_reg};
    assign dx_abs  = dx_full[O-1] ? (~dx_full + 1'b1) : dx_full;
    assign dy_abs  = dy_full[O-1] ? (~dy_full + 1'b1) : dy_full;
    assign mx_next = {sx[C-1], sx} + {prev_x_reg[C-1], prev_x_reg};
    assign my_next = {sy[C-1], sy} + {prev_y_reg[C-1], prev_y_reg};

    // Magnitudes of candidate and kept opening
    logic [O-1:0] mx_mag, my_mag, bx_mag, by_mag;
    assign mx_mag = mx_reg[O-1] ? (~mx_reg + 1'b1) : mx_reg;
    assign my_mag = my_reg[O-1] ? (~my_reg + 1'b1) : my_reg;
    assign bx_mag = best_x_reg[O-1] ? (~best_x_reg + 1'b1) : best_x_reg;
    assign by_mag = best_y_reg[O-1] ? (~best_y_reg + 1'b1) : best_y_reg;

    // Select multiplier operands
    logic [MUL_W-1:0] mul_a, mul_b;
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = MUL_W'(dxm_reg);
                mul_b = MUL_W'(dxm_reg);
            end
            MUL_DY:
            begin
                mul_a = MUL_W'(dym_reg);
                mul_b = MUL_W'(dym_reg);
            end
            MUL_AB:
            begin
                mul_a = MUL_W'(mx_mag);
                mul_b = MUL_W'(by_mag);
            end
            MUL_BA:
            begin
                mul_a = MUL_W'(bx_mag);
                mul_b = MUL_W'(my_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Gap length test on squared lengths
    logic [P_W:0] d2_sum;
    assign d2_sum = {1'b0, d2_reg} + {1'b0, p_reg};

    // Cosine compare: sign classes first, then |mx*yb| against |bx*my|
    logic mx_zero, mx_pos, mx_neg, bx_zero, bx_pos, bx_neg, beats;
    assign mx_zero = (mx_reg == '0);
    assign mx_neg  = mx_reg[O-1];
    assign mx_pos  = !mx_zero && !mx_neg;
    assign bx_zero = (best_x_reg == '0);
    assign bx_neg  = best_x_reg[O-1];
    assign bx_pos  = !bx_zero && !bx_neg;

    always_comb
    begin
        priority if (mx_zero && (my_reg == '0))
        begin
            beats = 1'b0;
        end
        else if (!have_best_reg)
        begin
            beats = (my_reg != '0) || mx_pos;
        end
        else if ((mx_pos != bx_pos) || (mx_neg != bx_neg))
        begin
            beats = (mx_pos && !bx_pos) || (mx_zero && bx_neg);
        end
        else if (mx_zero)
        begin
            beats = 1'b0;
        end
        else if (mx_pos)
        begin
            beats = cross_reg > p_reg;
        end
        else
        begin
            beats = p_reg > cross_reg;
        end
    end

    // Hold the squared least gap; square it once on each write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_sq_reg <= MIN_GAP_SQ_RESET;
        end
        else if (cfg_we)
        begin
            min_gap_sq_reg <= MIN_GAP_SQ_W'(cfg_wdata) * MIN_GAP_SQ_W'(cfg_wdata);
        end
    end

    // Capture the segment and run the shared multiplier
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            end_x_reg <= ex;
            end_y_reg <= ey;
            last_reg  <= in_last;
            dxm_reg   <= dx_abs[C-1:0];
            dym_reg   <= dy_abs[C-1:0];
            mx_reg    <= mx_next;
            my_reg    <= my_next;
        end
        if (cmd.mul_en)
        begin
            p_reg <= P_W'(mul_a) * P_W'(mul_b);
        end
        if (cmd.load_d2)
        begin
            d2_reg <= p_reg;
        end
        if (cmd.load_cross)
        begin
            cross_reg <= p_reg;
        end
    end

    // Advance scan state: keep best, keep end point, clear after the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            have_best_reg <= 1'b0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end
        else if (cmd.emit)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            have_prev_reg <= 1'b0;
            have_best_reg <= 1'b0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
        end
        else
        begin
            if (cmd.decide && beats)
            begin
                have_best_reg <= 1'b1;
                best_x_reg    <= mx_reg;
                best_y_reg    <= my_reg;
            end
            if (cmd.update_prev)
            begin
                prev_x_reg    <= end_x_reg;
                prev_y_reg    <= end_y_reg;
                have_prev_reg <= 1'b1;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            found_reg <= have_best_reg;
            ox_reg    <= have_best_reg ? best_x_reg : '0;
            oy_reg    <= have_best_reg ? best_y_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_user  = found_reg;
    assign out_data  = OUT_DATA_W'({oy_reg, ox_reg});

    assign status.have_prev = have_prev_reg;
    assign status.gap_ok    = d2_sum >= (P_W + 1)'(min_gap_sq_reg);
    assign status.last      = last_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

FILE: design/frontmost_gap_finder.sv
// IDLE takes a segment; the first of a scan goes to FINISH, others run SQ_DX, SQ_DY, GAP
// and, for a long enough gap, CROSS and DECIDE, then FINISH. One shared multiplier serves
// dx^2, dy^2 and both cross products. One segment is in flight at a time; the next is
// taken once the previous ends. The last segment's result leaves through an output
// register; a new segment is accepted while it waits. Reset (rst_n, asynchronous, active
// low) clears the scan state, empties the output register and sets min_gap to 1000.
module frontmost_gap_finder #(
    parameter int COORD_BITS = fgf_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fgf_pkg::MIN_GAP_W-1:0] cfg_wdata,   // min_gap
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_DATA_W-1:0]          s_tdata,     // start_x, start_y, end_x, end_y
    input  logic                          s_tlast,     // last_segment
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_DATA_W-1:0]         m_tdata,     // opening_x2, opening_y2
    output logic                          m_tuser      // found
);
    import fgf_pkg::*;

    cmd_t    cmd;
    status_t status;

    fgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fgf_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: tb/sv/frontmost_gap_finder_checker.sv
// Checker for the gap finder: follows the segment stream, predicts each scan result, compares.
module frontmost_gap_finder_checker #(
    parameter int COORD_BITS = fgf_pkg::COORD_BITS_DEF,
    parameter int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_DATA_W = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fgf_pkg::MIN_GAP_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [IN_DATA_W-1:0]          s_tdata,     // start_x, start_y, end_x, end_y
    input  logic                          s_tlast,     // last_segment
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [OUT_DATA_W-1:0]         m_tdata,     // opening_x2, opening_y2
    input  logic                          m_tuser,     // found
    output int                            pending,
    output int                            fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_BITS:0] x2;
        logic signed [COORD_BITS:0] y2;
    } opening_t;

    // Predicted block state
    logic [fgf_pkg::MIN_GAP_W-1:0] min_gap;
    logic signed [COORD_BITS-1:0]  tail_x;
    logic signed [COORD_BITS-1:0]  tail_y;
    logic                          tail_valid;
    logic                          best_valid;
    logic signed [COORD_BITS:0]    best_x2;
    logic signed [COORD_BITS:0]    best_y2;

    opening_t openings_due[$];
    opening_t got;
    opening_t want;
    int       mismatches = 0;

    function automatic int sign_of(input longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // True when the gap midpoint (ax, ay) points further forward than the kept best
    function automatic bit more_frontal(input longint ax, input longint ay);
        logic [127:0] xa2;
        logic [127:0] xb2;
        logic [127:0] na;
        logic [127:0] nb;
        int           sa;
        int           sb;
        if (ax == 0 && ay == 0)
            return 1'b0;
        if (!best_valid)
            return (ay != 0) || (ax > 0);
        sa = sign_of(ax);
        sb = sign_of(best_x2);
        if (sa != sb)
            return sa > sb;
        if (sa == 0)
            return 1'b0;
        xa2 = 128'(ax * ax);
        xb2 = 128'(longint'(best_x2) * longint'(best_x2));
        na  = xa2 + 128'(ay * ay);
        nb  = xb2 + 128'(longint'(best_y2) * longint'(best_y2));
        // Compare cos^2 by cross-multiplying; the order flips for negative cosines
        if (sa > 0)
            return xa2 * nb > xb2 * na;
        return xb2 * na > xa2 * nb;
    endfunction

    task automatic clear_scan();
        tail_x     = '0;
        tail_y     = '0;
        tail_valid = 1'b0;
        best_valid = 1'b0;
        best_x2    = '0;
        best_y2    = '0;
    endtask

    // Advance the prediction by one accepted segment
    task automatic scan_segment(input logic [IN_DATA_W-1:0] data, input logic is_last);
        longint           sx;
        longint           sy;
        longint           ex;
        longint           ey;
        longint           dx;
        longint           dy;
        longint           mx;
        longint           my;
        longint unsigned  dist_sq;
        longint unsigned  gap_sq;
        opening_t         res;
        sx = $signed(data[0 +: COORD_BITS]);
        sy = $signed(data[COORD_BITS +: COORD_BITS]);
        ex = $signed(data[2 * COORD_BITS +: COORD_BITS]);
        ey = $signed(data[3 * COORD_BITS +: COORD_BITS]);
        if (tail_valid)
        begin
            dx      = sx - tail_x;
            dy      = sy - tail_y;
            dist_sq = dx * dx + dy * dy;
            gap_sq  = min_gap;
            gap_sq  = gap_sq * gap_sq;
            if (dist_sq >= gap_sq)
            begin
                mx = tail_x + sx;
                my = tail_y + sy;
                if (more_frontal(mx, my))
                begin
                    best_valid = 1'b1;
                    best_x2    = mx;
                    best_y2    = my;
                end
            end
        end
        if (!is_last)
        begin
            tail_x     = ex;
            tail_y     = ey;
            tail_valid = 1'b1;
        end
        else
        begin
            res.found = best_valid;
            res.x2    = best_valid ? best_x2 : '0;
            res.y2    = best_valid ? best_y2 : '0;
            openings_due.insert(openings_due.size(), res);
            clear_scan();
        end
    endtask

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap = fgf_pkg::MIN_GAP_RESET;
            clear_scan();
            openings_due.delete();
            mismatches = 0;
        end
        else
        begin
            // Compare an output transaction with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.found = m_tuser;
                got.x2    = m_tdata[0 +: COORD_BITS + 1];
                got.y2    = m_tdata[COORD_BITS + 1 +: COORD_BITS + 1];
                if (openings_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result found=%0b x2=%0d y2=%0d",
                                 $time, got.found, got.x2, got.y2);
                    mismatches++;
                end
                else
                begin
                    want = openings_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: wrong result: found exp %0b got %0b, ",
                                      "x2 exp %0d got %0d, y2 exp %0d got %0d"},
                                     $time, want.found, got.found, want.x2, got.x2,
                                     want.y2, got.y2);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                min_gap = cfg_wdata;
            if (s_tvalid && s_tready)
                scan_segment(s_tdata, s_tlast);
        end
        // Leftover predictions count as failures
        pending    = openings_due.size();
        fail_count = mismatches + openings_due.size();
    end

endmodule

FILE: tb/sv/frontmost_gap_finder_tb.sv
// Testbench top for the gap finder: clock, reset, segment stimulus, output stalls, verdict.
module frontmost_gap_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS   = fgf_pkg::COORD_BITS_DEF;
    localparam int IN_DATA_W    = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((2 * (COORD_BITS + 1) + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_NS     = 5_000_000;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 140;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [fgf_pkg::MIN_GAP_W-1:0] cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [IN_DATA_W-1:0]          s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [OUT_DATA_W-1:0]         m_tdata;
    logic                          m_tuser;
    int                            pending;
    int                            fail_count;

    // Stimulus bookkeeping
    int tail_x  = 0;
    int tail_y  = 0;
    int cur_gap = fgf_pkg::MIN_GAP_RESET;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    frontmost_gap_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    frontmost_gap_finder_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run
    initial
    begin
        #LIMIT_NS;
        $display("frontmost_gap_finder: mismatch");
        $finish;
    end

    // Output side: stall a random number of cycles before each result
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic int clamp_coord(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Coordinate drawn from the whole range, a near-origin window or the extremes
    function automatic int rand_coord(input int mode);
        logic signed [COORD_BITS-1:0] r;
        case (mode)
            0:
            begin
                r = COORD_BITS'($urandom);
                return r;
            end
            1: return int'($urandom_range(0, 6000)) - 3000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    // Present one segment after a random gap and hold it until taken
    task automatic send_segment(input int sx, input int sy, input int ex, input int ey,
                                input logic is_last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= IN_DATA_W'({ey[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                                sy[COORD_BITS-1:0], sx[COORD_BITS-1:0]});
        s_tlast  <= is_last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        tail_x = ex;
        tail_y = ey;
    endtask

    // Drop valid, wait for every result, then let the block run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_gap(input int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[fgf_pkg::MIN_GAP_W-1:0];
        cur_gap    = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random scans: starts near the previous end, along fixed directions or anywhere
    task automatic run_random_scans(input int items);
        int sent;
        int len;
        int sx;
        int sy;
        int ex;
        int ey;
        int spread;
        int dx;
        int dy;
        int k;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(0, 9))
                0:       len = 1;
                1:       len = $urandom_range(15, 40);
                default: len = $urandom_range(2, 10);
            endcase
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        sx = rand_coord(0);
                        sy = rand_coord(0);
                    end
                    3, 4:
                    begin
                        spread = 2 * cur_gap + 8;
                        sx = clamp_coord(tail_x + int'($urandom_range(0, 2 * spread)) - spread);
                        sy = clamp_coord(tail_y + int'($urandom_range(0, 2 * spread)) - spread);
                    end
                    5, 6:
                    begin
                        // Midpoints along a few directions give ties and origin hits
                        dx = int'($urandom_range(0, 3)) - 1;
                        dy = int'($urandom_range(0, 3)) - 1;
                        k  = $urandom_range(1, 16000);
                        sx = clamp_coord(dx * k - tail_x);
                        sy = clamp_coord(dy * k - tail_y);
                    end
                    7:
                    begin
                        sx = rand_coord(2);
                        sy = rand_coord(2);
                    end
                    default:
                    begin
                        sx = rand_coord(1);
                        sy = rand_coord(1);
                    end
                endcase
                ex = rand_coord($urandom_range(0, 2));
                ey = rand_coord($urandom_range(0, 2));
                send_segment(sx, sy, ex, ey, i == len - 1);
                sent++;
            end
        end
    endtask

    // Reset, directed scans, random phases, verdict
    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lone last segment: nothing found
        send_segment(0, 0, 0, 0, 1'b1);
        // Forward gap kept against one behind, a weaker one, a short one and one at the origin
        send_segment(-5, -5, 1000, 0, 1'b0);
        send_segment(3000, 0, -1000, 0, 1'b0);
        send_segment(-3000, 0, 500, 500, 1'b0);
        send_segment(1500, 1500, 10, 0, 1'b0);
        send_segment(20, 0, -500, 0, 1'b0);
        send_segment(500, 0, 0, 0, 1'b1);
        // Equal cosine later: the first gap stays
        send_segment(0, 0, 0, 0, 1'b0);
        send_segment(1000, 1000, 0, 0, 1'b0);
        send_segment(2000, 2000, 0, 0, 1'b0);
        send_segment(0, -2000, 0, 0, 1'b1);
        // Backward half only, then a sideways gap
        send_segment(0, 0, 0, 0, 1'b0);
        send_segment(-3000, -100, 0, 0, 1'b0);
        send_segment(-3000, -3000, 0, 0, 1'b0);
        send_segment(0, 5000, 0, 0, 1'b1);
        // Extreme coordinates
        send_segment(32767, 32767, -32768, -32768, 1'b0);
        send_segment(32767, -32768, 32767, 32767, 1'b1);

        // Zero minimum: zero-length gaps count, midpoints at the output extremes
        write_min_gap(0);
        send_segment(0, 0, -32768, -32768, 1'b0);
        send_segment(-32768, -32768, 32767, 32767, 1'b0);
        send_segment(32767, 32767, 5, 5, 1'b0);
        send_segment(5, 5, 0, 0, 1'b1);

        // Largest minimum: only full-span gaps count
        write_min_gap(65535);
        send_segment(0, 0, -32768, 0, 1'b0);
        send_segment(32767, 0, 0, -32768, 1'b0);
        send_segment(0, 32767, 0, 0, 1'b1);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       write_min_gap(fgf_pkg::MIN_GAP_RESET);
                1:       write_min_gap($urandom_range(0, 65535));
                2:       write_min_gap(0);
                3:       write_min_gap($urandom_range(1, 200));
                4:       write_min_gap(65535);
                5:       write_min_gap($urandom_range(500, 5000));
                default: write_min_gap($urandom_range(0, 3000));
            endcase
            tx_calm = (phase % 3 == 2);
            rx_calm = (phase % 4 == 3);
            run_random_scans(PHASE_ITEMS);
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();
        if (fail_count == 0)
            $display("frontmost_gap_finder: match");
        else
            $display("frontmost_gap_finder: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
design/fgf_pkg.sv
design/fgf_ctrl.sv
design/fgf_datapath.sv
design/frontmost_gap_finder.sv
tb/sv/frontmost_gap_finder_checker.sv
tb/sv/frontmost_gap_finder_tb.sv
